// File: design/button_press_length_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// Button press length classifier assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_LENGTH_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_LENGTH_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define BPLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bplc assertion failed");
// Consequent in the cycle after the antecedent.
`define BPLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bplc assertion failed");
`else
`define BPLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BPLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/bplc_pkg.sv
// ----------------------------------------------------------------------------
// Button press length classifier package
// Shared types, register map and reset values.
// ----------------------------------------------------------------------------
package bplc_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int CNT_W      = 16;

	localparam int BLINK_PERIOD_DEF = 64;

	localparam logic [CNT_W-1:0] SHORT_MIN_RST  = 16'd20;
	localparam logic [CNT_W-1:0] MEDIUM_MIN_RST = 16'd512;
	localparam logic [CNT_W-1:0] LONG_MIN_RST   = 16'd1536;
	localparam logic [CNT_W-1:0] TOO_LONG_RST   = 16'd3072;

	typedef enum logic [1:0] {
		REG_SHORT_MIN  = 2'd0,
		REG_MEDIUM_MIN = 2'd1,
		REG_LONG_MIN   = 2'd2,
		REG_TOO_LONG   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLASS_NONE   = 2'd0,
		CLASS_SHORT  = 2'd1,
		CLASS_MEDIUM = 2'd2,
		CLASS_LONG   = 2'd3
	} press_class_t;

	typedef struct packed {
		logic [CNT_W-1:0] short_min;
		logic [CNT_W-1:0] medium_min;
		logic [CNT_W-1:0] long_min;
		logic [CNT_W-1:0] too_long;
	} cfg_t;

	typedef struct packed {
		logic         indicator;
		logic         action;
		press_class_t cls;
		logic         cls_valid;
	} result_t;

endpackage

// File: design/bplc_regs.sv
// ----------------------------------------------------------------------------
// Button press length classifier configuration registers
// APB-style register file holding the four band thresholds.
// ----------------------------------------------------------------------------
module bplc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bplc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bplc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bplc_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output bplc_pkg::cfg_t                   cfg
);
	import bplc_pkg::*;

	cfg_t             cfg_q;
	reg_idx_t         idx;
	logic             wr_en;
	logic [CNT_W-1:0] rd_val;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min  <= SHORT_MIN_RST;
			cfg_q.medium_min <= MEDIUM_MIN_RST;
			cfg_q.long_min   <= LONG_MIN_RST;
			cfg_q.too_long   <= TOO_LONG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SHORT_MIN:  cfg_q.short_min  <= pwdata[CNT_W-1:0];
				REG_MEDIUM_MIN: cfg_q.medium_min <= pwdata[CNT_W-1:0];
				REG_LONG_MIN:   cfg_q.long_min   <= pwdata[CNT_W-1:0];
				REG_TOO_LONG:   cfg_q.too_long   <= pwdata[CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SHORT_MIN:  rd_val = cfg_q.short_min;
			REG_MEDIUM_MIN: rd_val = cfg_q.medium_min;
			REG_LONG_MIN:   rd_val = cfg_q.long_min;
			REG_TOO_LONG:   rd_val = cfg_q.too_long;
		endcase
	end

	assign prdata = {{(APB_DATA_W - CNT_W){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule

// File: design/bplc_core.sv
// ----------------------------------------------------------------------------
// Button press length classifier core
// Press counter, blink phase, lamp state and release classification.
// ----------------------------------------------------------------------------
module bplc_core #(
	parameter int BLINK_PERIOD = bplc_pkg::BLINK_PERIOD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                button,
	input  bplc_pkg::cfg_t      cfg,
	output bplc_pkg::result_t   res
);
	import bplc_pkg::*;

	localparam int PhaseW = $clog2(BLINK_PERIOD);
	localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(BLINK_PERIOD - 1);

	logic [CNT_W-1:0]  count_q, count_nxt;
	logic [PhaseW-1:0] phase_q, phase_nxt;
	logic              armed_q, armed_nxt;
	logic              ind_q, ind_nxt;
	logic              act_q, act_nxt;
	press_class_t      cls;
	logic              cls_valid;

	function automatic logic in_band(logic [CNT_W-1:0] v, logic [CNT_W-1:0] lo,
			logic [CNT_W-1:0] hi);
		return (v >= lo) && (v < hi);
	endfunction

	always_comb begin
		count_nxt = count_q;
		phase_nxt = phase_q;
		armed_nxt = armed_q;
		ind_nxt   = ind_q;
		act_nxt   = act_q;
		cls       = CLASS_NONE;
		cls_valid = 1'b0;
		if (button) begin
			// saturate; phase tracks count modulo the blink period
			if (count_q != '1) begin
				count_nxt = count_q + CNT_W'(1);
				phase_nxt = (phase_q == PhaseLast) ? '0 : phase_q + PhaseW'(1);
			end
			armed_nxt = 1'b1;
			priority if (in_band(count_nxt, cfg.medium_min, cfg.long_min)) begin
				ind_nxt = 1'b1;
			end else if (in_band(count_nxt, cfg.long_min, cfg.too_long)) begin
				if (phase_nxt == PhaseLast) begin
					ind_nxt = !ind_q;
				end
			end else if (count_nxt >= cfg.too_long) begin
				ind_nxt = 1'b0;
			end
		end else if (armed_q) begin
			priority if (in_band(count_q, cfg.short_min, cfg.medium_min)) begin
				cls = CLASS_SHORT;
			end else if (in_band(count_q, cfg.medium_min, cfg.long_min)) begin
				cls = CLASS_MEDIUM;
			end else if (in_band(count_q, cfg.long_min, cfg.too_long)) begin
				cls = CLASS_LONG;
			end else begin
				cls = CLASS_NONE;
			end
			ind_nxt   = 1'b0;
			count_nxt = '0;
			phase_nxt = '0;
			armed_nxt = 1'b0;
			cls_valid = 1'b1;
			unique case (cls)
				CLASS_SHORT:  act_nxt = !act_q;
				CLASS_MEDIUM: act_nxt = 1'b1;
				CLASS_LONG:   act_nxt = 1'b0;
				CLASS_NONE:   act_nxt = act_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			armed_q <= 1'b0;
			ind_q   <= 1'b0;
			act_q   <= 1'b1;
		end else if (adv) begin
			count_q <= count_nxt;
			phase_q <= phase_nxt;
			armed_q <= armed_nxt;
			ind_q   <= ind_nxt;
			act_q   <= act_nxt;
		end
	end

	assign res.indicator = ind_nxt;
	assign res.action    = act_nxt;
	assign res.cls       = cls;
	assign res.cls_valid = cls_valid;

endmodule

// File: design/button_press_length_classifier_top.sv
// ----------------------------------------------------------------------------
// Button press length classifier top level
// Takes one button level per item and returns one item of lamp levels and,
// on release, the press class. An item is taken every clock cycle while
// in_stall is low; its result passes through the input register and then
// the result register, and the update of the press counter and lamp state
// between them gives one item per clock while out_stall is low. The
// four band thresholds are written over the APB port at byte addresses
// 0x0, 0x4, 0x8 and 0xC.
// ----------------------------------------------------------------------------
`include "button_press_length_classifier_top_defines.svh"

module button_press_length_classifier_top #(
	parameter int BLINK_PERIOD = bplc_pkg::BLINK_PERIOD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bplc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bplc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bplc_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_pressed,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             indicator_lamp,
	output logic                             action_lamp,
	output logic [1:0]                       press_class,
	output logic                             class_valid
);
	import bplc_pkg::*;

	cfg_t         cfg;
	result_t      res;
	logic         valid_s1;
	logic         button_s1;
	logic         adv;
	logic         in_acc;
	logic         out_valid_s2;
	logic         ind_s2;
	logic         act_s2;
	press_class_t cls_s2;
	logic         cls_valid_s2;

	bplc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bplc_core #(
		.BLINK_PERIOD (BLINK_PERIOD)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.button (button_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// advance the held item whenever the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			button_s1 <= button_pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ind_s2       <= res.indicator;
			act_s2       <= res.action;
			cls_s2       <= res.cls;
			cls_valid_s2 <= res.cls_valid;
		end
	end

	assign out_valid      = out_valid_s2;
	assign indicator_lamp = ind_s2;
	assign action_lamp    = act_s2;
	assign press_class    = cls_s2;
	assign class_valid    = cls_valid_s2;

	`BPLC_ASSERT_SAME(a_release_clears_indicator, clk, arst_n, out_valid_s2 && cls_valid_s2, !ind_s2)
	`BPLC_ASSERT_SAME(a_class_only_on_release, clk, arst_n, out_valid_s2 && (cls_s2 != CLASS_NONE), cls_valid_s2)
	`BPLC_ASSERT_NEXT(a_held_item_not_classified, clk, arst_n, adv && button_s1, !cls_valid_s2)
	`BPLC_ASSERT_NEXT(a_advance_fills_output, clk, arst_n, adv, out_valid_s2)

endmodule
